FILE: rtl/bole_pkg.sv
// ---------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Command, status and cell-mode codes, and the control word that is
// broadcast along the cell chain.
// ---------------------------------------------------------------------------
package bole_pkg;

  localparam int DATA_W = 32;
  // Wide enough for any position or count at the largest supported depth.
  localparam int PTR_W  = 9;

  localparam logic [2:0] CMD_HEAD   = 3'd0;
  localparam logic [2:0] CMD_TAIL   = 3'd1;
  localparam logic [2:0] CMD_AT     = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_FIRST  = 3'd4;
  localparam logic [2:0] CMD_LAST   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;
  localparam logic [2:0] CMD_DUMP   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_SHIFT  = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  // pos is the insert position in insert mode and the wrap cell in rotate mode.
  typedef struct packed {
    logic [1:0]       mode;
    logic [PTR_W-1:0] pos;
  } cell_ctl_t;

endpackage

FILE: rtl/bole_cell.sv
// ---------------------------------------------------------------------------
// bole_cell: one list entry of the cell chain
// Holds one value and takes it from its left or right neighbor, the new
// value or the head of the list, as the broadcast control word selects.
// ---------------------------------------------------------------------------
module bole_cell
  import bole_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] value_in,
  input  logic [DATA_W-1:0] head_in,
  input  logic [DATA_W-1:0] left_in,
  input  logic [DATA_W-1:0] right_in,
  output logic [DATA_W-1:0] data
);

  localparam logic [PTR_W-1:0] MY_POS = PTR_W'(IDX);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.mode)
      MODE_INSERT: begin
        if (MY_POS == ctl.pos) begin
          data_next = value_in;
        end else if (MY_POS > ctl.pos) begin
          data_next = left_in;
        end
      end
      MODE_SHIFT: begin
        data_next = right_in;
      end
      MODE_ROTATE: begin
        // The cell at the tail of the list receives the old head.
        data_next = (MY_POS == ctl.pos) ? head_in : right_in;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: rtl/bounded_ordered_list_engine_unit.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_unit: ordered list of signed values in a cell chain
// Insert, remove, clear and dump commands on a list of up to DEPTH entries.
// ---------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid/in_ready) carries command,
// value and index. Results leave on the output channel (out_valid/out_ready)
// through one output register, each with status, count, element and last.
// Head, tail and indexed insert, remove first, remove last and clear
// register their result at the edge that accepts the request.
// Remove of a value rotates the whole list once past the head comparator,
// one entry per cycle after the accepting edge (the final step waits for
// the output register); its result is registered at the last rotation.
// A dump rotates the list the same way and emits one entry per cycle, from
// the cycle after the accepting edge, while the receiver takes them: count
// results in all, and last marks the final one. An empty list answers a
// remove or dump with status empty at the edge that accepts the request.
// A new request is taken only when no scan or dump is running and the output
// register is empty or being emptied in the same cycle.
// When the receiver stalls, the result holds in the output register and a
// dump or scan waits at the step that needs the output register.
// Reset (rst, synchronous) empties the list and the output register; the
// cell contents are not cleared, since only entries below the count are read.
// ---------------------------------------------------------------------------
module bounded_ordered_list_engine_unit
  import bole_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic signed [DATA_W-1:0] value,
  input  logic [7:0]               index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic [CW-1:0]            count,
  output logic signed [DATA_W-1:0] element,
  output logic                     last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  logic [1:0]        state, state_next;
  logic [CW-1:0]     entry_count, entry_count_next;
  logic [CW-1:0]     remaining, remaining_next;
  logic              found, found_next;
  logic [DATA_W-1:0] key, key_next;

  logic              out_free;
  logic              accept_in;
  logic              ld;
  logic [1:0]        ld_status;
  logic [CW-1:0]     ld_count;
  logic [DATA_W-1:0] ld_elem;
  logic              ld_last;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] head;
  logic [PTR_W-1:0]  cnt_p, idx_p, ins_pos;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept_in = in_valid && in_ready;
  assign head      = cell_data[0];

  assign cnt_p   = PTR_W'(entry_count);
  assign idx_p   = PTR_W'(index);
  assign ins_pos = (idx_p >= cnt_p) ? cnt_p : idx_p;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    remaining_next   = remaining;
    found_next       = found;
    key_next         = key;
    ctl.mode         = MODE_HOLD;
    ctl.pos          = '0;
    ld               = 1'b0;
    ld_status        = ST_OK;
    ld_count         = entry_count;
    ld_elem          = '0;
    ld_last          = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          case (command)
            CMD_HEAD, CMD_TAIL, CMD_AT: begin
              ld = 1'b1;
              if (entry_count == FULL_COUNT) begin
                ld_status = ST_FULL;
              end else begin
                ctl.mode = MODE_INSERT;
                if (command == CMD_HEAD) begin
                  ctl.pos = '0;
                end else if (command == CMD_TAIL) begin
                  ctl.pos = cnt_p;
                end else begin
                  ctl.pos = ins_pos;
                end
                entry_count_next = entry_count + ONE;
                ld_count         = entry_count + ONE;
              end
            end
            CMD_REMOVE: begin
              if (entry_count == '0) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next     = S_SCAN;
                remaining_next = entry_count;
                found_next     = 1'b0;
                key_next       = value;
              end
            end
            CMD_FIRST, CMD_LAST: begin
              ld = 1'b1;
              if (entry_count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                if (command == CMD_FIRST) begin
                  ctl.mode = MODE_SHIFT;
                end
                entry_count_next = entry_count - ONE;
                ld_count         = entry_count - ONE;
              end
            end
            CMD_CLEAR: begin
              ld               = 1'b1;
              entry_count_next = '0;
              ld_count         = '0;
            end
            default: begin
              if (entry_count == '0) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next     = S_DUMP;
                remaining_next = entry_count;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // The final step writes the result, so it waits for the output register.
        if ((remaining != ONE) || out_free) begin
          if (!found && (head == key)) begin
            ctl.mode         = MODE_SHIFT;
            entry_count_next = entry_count - ONE;
            found_next       = 1'b1;
          end else begin
            ctl.mode = MODE_ROTATE;
            ctl.pos  = cnt_p - PTR_W'(1);
          end
          remaining_next = remaining - ONE;
          if (remaining == ONE) begin
            ld         = 1'b1;
            ld_status  = found_next ? ST_OK : ST_NOTFOUND;
            ld_count   = entry_count_next;
            state_next = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.mode       = MODE_ROTATE;
          ctl.pos        = cnt_p - PTR_W'(1);
          ld             = 1'b1;
          ld_elem        = head;
          ld_last        = (remaining == ONE);
          remaining_next = remaining - ONE;
          if (remaining == ONE) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      remaining   <= '0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      remaining   <= remaining_next;
      found       <= found_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (ld) begin
      status  <= ld_status;
      count   <= ld_count;
      element <= ld_elem;
      last    <= ld_last;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_left
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_final
      assign right_d = cell_data[g];
    end else begin : g_mid_right
      assign right_d = cell_data[g+1];
    end
    bole_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .value_in (value),
      .head_in  (head),
      .left_in  (left_d),
      .right_in (right_d),
      .data     (cell_data[g])
    );
  end

endmodule
